FILE: src/bpp_pkg.sv
package bpp_pkg;

  localparam int ID_W      = 16;
  localparam int DEPTH_W   = 5;
  localparam int IDX_W     = 8;
  localparam int POS_OUT_W = 5;
  localparam int TOTAL_W   = 12;
  localparam int ITOT_W    = 9;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT     = 5'd16;
  localparam logic [IDX_W-1:0]   IDX_MAX         = 8'd255;
  localparam logic [TOTAL_W-1:0] RESET_MAX_TOTAL = 12'd400;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DEPTH   = 3'd1,
    ST_TOTAL   = 3'd2,
    ST_ABORTED = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PLACE,
    S_EMIT
  } state_t;

endpackage

FILE: src/bpp_ram.sv
module bpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/bit_plane_packer_unit.sv
// channel   direction  beat contents
// in_*      input      first, pattern_id, bit_depth
// out_*     output     image_index, bit_position, reused, status, image_total
// cfg_*     input      max_total_bits write, no handshake
//
// A new pattern passes through accept, limit check, a scan with one placement table read
// per stored entry (the read data is registered in the RAM) that a closing check ends,
// placement and result load; an empty table gives no reads. A reuse match on a stored entry
// stops the scan early and goes straight to the result load. Limit check errors skip the
// scan and placement. in_ready is low from accept until the result is loaded.
// Reset is synchronous; the table needs no clearing pass, the fill count bounds reads.
// A stalled result holds in the output register while the next beat is accepted.
module bit_plane_packer_unit
  import bpp_pkg::*;
#(
  parameter int MAX_PATTERNS = 256,
  parameter int IMAGE_BITS   = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [TOTAL_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_first,
  input  logic [ID_W-1:0]      in_pattern_id,
  input  logic [DEPTH_W-1:0]   in_bit_depth,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_image_index,
  output logic [POS_OUT_W-1:0] out_bit_position,
  output logic                 out_reused,
  output logic [2:0]           out_status,
  output logic [ITOT_W-1:0]    out_image_total
);

  localparam int AW       = $clog2(MAX_PATTERNS);
  localparam int CW       = $clog2(MAX_PATTERNS + 1);
  localparam int BITS_MAX = (IMAGE_BITS > 16) ? IMAGE_BITS : 16;
  localparam int PW       = $clog2(BITS_MAX + 1);
  localparam int SW       = ((PW > DEPTH_W) ? PW : DEPTH_W) + 1;
  localparam int ENTRY_W  = ID_W + DEPTH_W + IDX_W + PW;

  state_t state_r, state_nxt;

  logic                 first_r;
  logic [ID_W-1:0]      id_r;
  logic [DEPTH_W-1:0]   depth_r;

  logic [TOTAL_W-1:0]   max_total_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [PW-1:0]        bits_r, bits_nxt;
  logic [IDX_W-1:0]     img_r, img_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 aborted_r, aborted_nxt;
  logic [TOTAL_W-1:0]   sum_r, sum_nxt;
  logic [CW-1:0]        issue_r, issue_nxt;
  logic                 pend_r, pend_nxt;

  logic [IDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic [PW-1:0]        res_pos_r, res_pos_nxt;
  logic                 res_reused_r, res_reused_nxt;
  status_t              res_status_r, res_status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic                 out_reused_r;
  logic [2:0]           out_status_r;
  logic [ITOT_W-1:0]    out_itot_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 load_out;

  logic                 eff_aborted;
  logic [TOTAL_W-1:0]   eff_total;
  logic [TOTAL_W:0]     sum_wide;
  status_t              chk_status;

  logic                 rd_en;
  logic [ENTRY_W-1:0]   rd_data;
  logic [ID_W-1:0]      rd_id;
  logic [DEPTH_W-1:0]   rd_depth;
  logic [IDX_W-1:0]     rd_idx;
  logic [PW-1:0]        rd_pos;
  logic                 scan_hit;
  logic                 scan_done;

  logic [SW-1:0]        pos_sum;
  logic                 wrap;
  logic                 place_full;
  logic [IDX_W-1:0]     new_idx;
  logic [PW-1:0]        new_pos;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // limit checks, counters seen as cleared when the beat opens a sequence
  always_comb begin
    eff_aborted = first_r ? 1'b0 : aborted_r;
    eff_total   = first_r ? '0 : total_r;
    sum_wide    = {1'b0, eff_total} + (TOTAL_W + 1)'(depth_r);
    if (eff_aborted) begin
      chk_status = ST_ABORTED;
    end else if (depth_r > DEPTH_LIMIT) begin
      chk_status = ST_DEPTH;
    end else if (sum_wide > {1'b0, max_total_r}) begin
      chk_status = ST_TOTAL;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign rd_id     = rd_data[ENTRY_W-1 -: ID_W];
  assign rd_depth  = rd_data[ENTRY_W-ID_W-1 -: DEPTH_W];
  assign rd_idx    = rd_data[PW +: IDX_W];
  assign rd_pos    = rd_data[PW-1:0];
  assign scan_hit  = pend_r && (rd_id == id_r) && (rd_depth == depth_r);
  assign scan_done = !pend_r && (issue_r >= count_r);

  always_comb begin
    pos_sum    = SW'(bits_r) + SW'(depth_r);
    wrap       = pos_sum > SW'(IMAGE_BITS);
    place_full = (count_r >= CW'(MAX_PATTERNS)) || (wrap && (img_r == IDX_MAX));
    new_idx    = wrap ? img_r + 8'd1 : img_r;
    new_pos    = wrap ? '0 : bits_r;
    wr_data    = {id_r, depth_r, new_idx, new_pos};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = (chk_status == ST_OK) ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_EMIT;
        end else if (scan_done) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  rd_en    = !scan_hit && (issue_r < count_r);
      S_PLACE: wr_en    = !place_full;
      S_EMIT:  load_out = out_free;
      default: begin
      end
    endcase
  end

  // packing state and result staging
  always_comb begin
    count_nxt      = count_r;
    bits_nxt       = bits_r;
    img_nxt        = img_r;
    total_nxt      = total_r;
    aborted_nxt    = aborted_r;
    sum_nxt        = sum_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    res_idx_nxt    = res_idx_r;
    res_pos_nxt    = res_pos_r;
    res_reused_nxt = res_reused_r;
    res_status_nxt = res_status_r;
    case (state_r)
      S_CHECK: begin
        if (first_r) begin
          count_nxt   = '0;
          bits_nxt    = '0;
          img_nxt     = '0;
          total_nxt   = '0;
          aborted_nxt = 1'b0;
        end
        res_idx_nxt    = '0;
        res_pos_nxt    = '0;
        res_reused_nxt = 1'b0;
        res_status_nxt = chk_status;
        if (chk_status == ST_DEPTH || chk_status == ST_TOTAL) begin
          aborted_nxt = 1'b1;
        end
        sum_nxt   = sum_wide[TOTAL_W-1:0];
        issue_nxt = '0;
        pend_nxt  = 1'b0;
      end
      S_SCAN: begin
        if (scan_hit) begin
          total_nxt      = sum_r;
          res_idx_nxt    = rd_idx;
          res_pos_nxt    = rd_pos;
          res_reused_nxt = 1'b1;
          res_status_nxt = ST_OK;
        end else begin
          pend_nxt = rd_en;
          if (rd_en) begin
            issue_nxt = issue_r + CW'(1);
          end
        end
      end
      S_PLACE: begin
        if (place_full) begin
          aborted_nxt    = 1'b1;
          res_status_nxt = ST_FULL;
        end else begin
          count_nxt      = count_r + CW'(1);
          img_nxt        = new_idx;
          bits_nxt       = wrap ? PW'(depth_r) : PW'(pos_sum);
          total_nxt      = sum_r;
          res_idx_nxt    = new_idx;
          res_pos_nxt    = new_pos;
          res_status_nxt = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  bpp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_PATTERNS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(issue_r[AW-1:0]),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_total_r  <= RESET_MAX_TOTAL;
      count_r      <= '0;
      bits_r       <= '0;
      img_r        <= '0;
      total_r      <= '0;
      aborted_r    <= 1'b0;
      issue_r      <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        max_total_r <= cfg_wr_data;
      end
      count_r      <= count_nxt;
      bits_r       <= bits_nxt;
      img_r        <= img_nxt;
      total_r      <= total_nxt;
      aborted_r    <= aborted_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_r <= in_first;
      id_r    <= in_pattern_id;
      depth_r <= in_bit_depth;
    end
    sum_r        <= sum_nxt;
    res_idx_r    <= res_idx_nxt;
    res_pos_r    <= res_pos_nxt;
    res_reused_r <= res_reused_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_idx_r    <= res_idx_r;
      out_pos_r    <= POS_OUT_W'(res_pos_r);
      out_reused_r <= res_reused_r;
      out_status_r <= res_status_r;
      out_itot_r   <= {1'b0, img_r} + ITOT_W'(1);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_image_index  = out_idx_r;
  assign out_bit_position = out_pos_r;
  assign out_reused       = out_reused_r;
  assign out_status       = out_status_r;
  assign out_image_total  = out_itot_r;

endmodule

FILE: src/bpp_checker.sv
module bpp_checker
  import bpp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [IDX_W-1:0]     out_image_index,
  input logic [POS_OUT_W-1:0] out_bit_position,
  input logic                 out_reused,
  input logic [2:0]           out_status,
  input logic [ITOT_W-1:0]    out_image_total
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_image_index) && $stable(out_bit_position)
      && $stable(out_image_total))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_image_index == '0) && (out_bit_position == '0) && !out_reused)
    else $error("error result carries a placement");

  a_reuse_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reused |-> (out_status == ST_OK) && (out_image_total != '0))
    else $error("reused result without ok status");

endmodule

bind bit_plane_packer_unit bpp_checker u_bpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_image_index (out_image_index),
  .out_bit_position(out_bit_position),
  .out_reused      (out_reused),
  .out_status      (out_status),
  .out_image_total (out_image_total)
);

FILE: verif/bit_plane_packer_unit_test.sv
`timescale 1ns / 1ps

module bit_plane_packer_unit_test;
  import bpp_pkg::*;

  localparam int TB_MAX_PATTERNS = 256;
  localparam int TB_IMAGE_BITS   = 24;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int HOLD_CYCLES     = 400;

  typedef struct packed {
    logic [IDX_W-1:0]     image_index;
    logic [POS_OUT_W-1:0] bit_position;
    logic                 reused;
    status_t              status;
    logic [ITOT_W-1:0]    image_total;
  } placement_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [TOTAL_W-1:0]   cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_first = 1'b0;
  logic [ID_W-1:0]      in_pattern_id = '0;
  logic [DEPTH_W-1:0]   in_bit_depth = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     out_image_index;
  logic [POS_OUT_W-1:0] out_bit_position;
  logic                 out_reused;
  logic [2:0]           out_status;
  logic [ITOT_W-1:0]    out_image_total;

  placement_result_t placement_q[$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  logic hold_active = 1'b0;

  logic [ID_W-1:0]    tbl_id    [TB_MAX_PATTERNS];
  logic [DEPTH_W-1:0] tbl_depth [TB_MAX_PATTERNS];
  logic [IDX_W-1:0]   tbl_index [TB_MAX_PATTERNS];
  logic [4:0]         tbl_pos   [TB_MAX_PATTERNS];
  int unsigned n_entries = 0;
  int unsigned plane_fill = 0;
  int unsigned cur_image = 0;
  int unsigned depth_sum = 0;
  bit seq_aborted = 1'b0;
  logic [TOTAL_W-1:0] limit_bits = RESET_MAX_TOTAL;

  bit_plane_packer_unit #(
    .MAX_PATTERNS(TB_MAX_PATTERNS),
    .IMAGE_BITS(TB_IMAGE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_first(in_first),
    .in_pattern_id(in_pattern_id),
    .in_bit_depth(in_bit_depth),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_image_index(out_image_index),
    .out_bit_position(out_bit_position),
    .out_reused(out_reused),
    .out_status(out_status),
    .out_image_total(out_image_total)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, placement_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic placement_result_t place_pattern(logic first, logic [ID_W-1:0] id,
                                                      logic [DEPTH_W-1:0] depth);
    placement_result_t r;
    int unsigned sum;
    int unsigned idx;
    int unsigned pos;
    int hit;
    int k;
    r = '0;
    r.status = ST_OK;
    if (first) begin
      n_entries = 0;
      plane_fill = 0;
      cur_image = 0;
      depth_sum = 0;
      seq_aborted = 1'b0;
    end
    if (seq_aborted) begin
      r.status = ST_ABORTED;
    end else if (depth > DEPTH_LIMIT) begin
      seq_aborted = 1'b1;
      r.status = ST_DEPTH;
    end else begin
      sum = depth_sum + depth;
      if (sum > limit_bits) begin
        seq_aborted = 1'b1;
        r.status = ST_TOTAL;
      end else begin
        hit = -1;
        for (k = 0; k < n_entries; k++) begin
          if (hit < 0 && tbl_id[k] == id && tbl_depth[k] == depth) hit = k;
        end
        if (hit >= 0) begin
          depth_sum = sum;
          r.image_index = tbl_index[hit];
          r.bit_position = tbl_pos[hit];
          r.reused = 1'b1;
        end else if (n_entries >= TB_MAX_PATTERNS) begin
          seq_aborted = 1'b1;
          r.status = ST_FULL;
        end else begin
          idx = cur_image;
          pos = plane_fill;
          if (pos + depth > TB_IMAGE_BITS) begin
            if (idx >= IDX_MAX) begin
              seq_aborted = 1'b1;
              r.status = ST_FULL;
            end else begin
              idx++;
              pos = 0;
            end
          end
          if (r.status == ST_OK) begin
            tbl_id[n_entries] = id;
            tbl_depth[n_entries] = depth;
            tbl_index[n_entries] = IDX_W'(idx);
            tbl_pos[n_entries] = 5'(pos);
            n_entries++;
            cur_image = idx;
            plane_fill = pos + depth;
            depth_sum = sum;
            r.image_index = IDX_W'(idx);
            r.bit_position = POS_OUT_W'(pos);
          end
        end
      end
    end
    r.image_total = ITOT_W'(cur_image + 1);
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : compare_placement
    placement_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (placement_q.size() == 0) begin
        $display("%0t unexpected beat, expected none actual index %0d status %0d",
                 $time, out_image_index, out_status);
        errors++;
      end else begin
        want = placement_q.pop_front();
        report_field("image_index", want.image_index, out_image_index);
        report_field("bit_position", want.bit_position, out_bit_position);
        report_field("reused", want.reused, out_reused);
        report_field("status", want.status, out_status);
        report_field("image_total", want.image_total, out_image_total);
      end
    end
    out_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    end
  end

  task automatic offer_pattern(logic first, logic [ID_W-1:0] id, logic [DEPTH_W-1:0] depth);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first <= first;
    in_pattern_id <= id;
    in_bit_depth <= depth;
    do @(posedge clk); while (!in_ready);
    placement_q.push_back(place_pattern(first, id, depth));
  endtask

  task automatic wait_for_placements();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_total_limit(logic [TOTAL_W-1:0] value);
    wait_for_placements();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_bits = value;
  endtask

  function automatic logic [TOTAL_W-1:0] pick_limit();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return 12'd3984;
      4, 5: return RESET_MAX_TOTAL;
      default: return TOTAL_W'($urandom);
    endcase
  endfunction

  task automatic check_directed_cases();
    offer_pattern(1'b1, 16'h0000, 5'd0);
    offer_pattern(1'b0, 16'hFFFF, 5'd16);
    offer_pattern(1'b0, 16'h0000, 5'd0);
    offer_pattern(1'b0, 16'h1234, 5'd8);
    offer_pattern(1'b0, 16'h00FF, 5'd0);
    offer_pattern(1'b0, 16'h0005, 5'd1);
    offer_pattern(1'b0, 16'hFFFF, 5'd16);
    offer_pattern(1'b0, 16'hFFFF, 5'd15);
    offer_pattern(1'b0, 16'h0001, 5'd17);
    offer_pattern(1'b0, 16'h0002, 5'd3);
    offer_pattern(1'b1, 16'hFFFF, 5'd31);
    offer_pattern(1'b1, 16'hFFFF, 5'd16);
    write_total_limit('0);
    offer_pattern(1'b1, 16'h7777, 5'd0);
    offer_pattern(1'b0, 16'h7777, 5'd1);
    offer_pattern(1'b0, 16'h7778, 5'd0);
    write_total_limit(12'd20);
    offer_pattern(1'b1, 16'h8888, 5'd16);
    offer_pattern(1'b0, 16'h8889, 5'd4);
    offer_pattern(1'b0, 16'h8888, 5'd16);
    offer_pattern(1'b1, 16'h8888, 5'd16);
    offer_pattern(1'b0, 16'h8888, 5'd4);
    offer_pattern(1'b0, 16'h8888, 5'd0);
    offer_pattern(1'b0, 16'h8888, 5'd1);
  endtask

  task automatic check_total_overflow();
    int k;
    write_total_limit('1);
    offer_pattern(1'b1, 16'hA5A5, 5'd16);
    for (k = 0; k < 254; k++) offer_pattern(1'b0, 16'hA5A5, 5'd16);
    offer_pattern(1'b0, 16'h5A5A, 5'd15);
    offer_pattern(1'b0, 16'h5A5A, 5'd1);
    offer_pattern(1'b0, 16'hA5A5, 5'd16);
    offer_pattern(1'b1, 16'hA5A5, 5'd16);
  endtask

  task automatic check_table_full();
    int k;
    logic [7:0] b;
    write_total_limit('1);
    for (k = 0; k < TB_MAX_PATTERNS; k++) begin
      b = 8'(k);
      offer_pattern(k == 0, {b, ~b}, 5'd13);
    end
    offer_pattern(1'b0, 16'h00FF, 5'd13);
    offer_pattern(1'b0, 16'hFF00, 5'd13);
    offer_pattern(1'b0, 16'h0000, 5'd0);
    offer_pattern(1'b0, 16'h00FF, 5'd13);
  endtask

  task automatic check_output_backpressure();
    logic [ID_W-1:0] id;
    int k;
    write_total_limit(12'd3984);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    id = ID_W'($urandom);
    hold_req = 1'b1;
    for (k = 0; k < 16; k++) begin
      offer_pattern(k == 0, id ^ ID_W'(k % 5), DEPTH_W'($urandom_range(16)));
    end
    wait_for_placements();
  endtask

  task automatic check_random_sequences(int n_items);
    logic [ID_W-1:0]    id_pool    [6];
    logic [DEPTH_W-1:0] depth_pool [6];
    logic [DEPTH_W-1:0] d;
    int sent;
    int len;
    int j;
    int p;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) write_total_limit(pick_limit());
      if ($urandom_range(99) < 80) begin
        for (j = 0; j < 6; j++) begin
          id_pool[j] = ID_W'($urandom);
          depth_pool[j] = DEPTH_W'($urandom_range(16));
        end
        len = $urandom_range(1, 30);
        for (j = 0; j < len; j++) begin
          p = $urandom_range(5);
          d = ($urandom_range(99) < 60) ? depth_pool[p] : DEPTH_W'($urandom_range(16));
          if ($urandom_range(99) < 2) d = DEPTH_W'($urandom_range(31, 17));
          offer_pattern(j == 0, id_pool[p], d);
        end
        sent += len;
      end else begin
        offer_pattern(1'($urandom), ID_W'($urandom), DEPTH_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 86;
    check_directed_cases();
    check_total_overflow();
    check_table_full();
    check_output_backpressure();
    send_idle_pct = 12;
    recv_idle_pct = 86;
    check_random_sequences(100);
    send_idle_pct = 86;
    recv_idle_pct = 12;
    check_random_sequences(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    check_random_sequences(70);
    wait_for_placements();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bpp_pkg.sv
src/bpp_ram.sv
src/bit_plane_packer_unit.sv
src/bpp_checker.sv
verif/bit_plane_packer_unit_test.sv
